// ===== sv/lzmd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzmd_pkg
// Shared types and constants of the marker-byte LZ77 decompressor.
// ----------------------------------------------------------------------------
package lzmd_pkg;

  localparam int WINDOW_BYTES_DEF = 131072;
  localparam int BURST_MAX_DEF    = 64;

  localparam logic [6:0] VARINT_MASK = 7'h7f;
  localparam int         VARINT_MORE = 7;

  typedef enum logic [2:0] {
    MODE_HEADER       = 3'd0,
    MODE_PLAIN        = 3'd1,
    MODE_AFTER_MARKER = 3'd2,
    MODE_LENGTH       = 3'd3,
    MODE_OFFSET       = 3'd4
  } lzmd_mode_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_BUSY   = 2'd1,
    ERR_OFFSET = 2'd2
  } lzmd_err_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_DECODE = 2'd1,
    S_READ   = 2'd2,
    S_EMIT   = 2'd3
  } lzmd_state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic read;
    logic emit;
  } lzmd_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic dec_result;
    logic dec_copy;
    logic copy_more;
  } lzmd_status_t;

endpackage

// ===== sv/lzmd_if.sv =====
// ----------------------------------------------------------------------------
// lzmd channel interfaces
// Valid/ready channels for compressed input and decompressed results.
// ----------------------------------------------------------------------------
interface lzmd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] in_byte;
  logic       last_of_block;

  modport source (output valid, action, in_byte, last_of_block, input ready);
  modport sink   (input valid, action, in_byte, last_of_block, output ready);
endinterface

interface lzmd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_error;
  logic [1:0]  error_code;
  logic        run_last;
  logic        copy_pending;
  logic [31:0] block_total;

  modport source (output valid, out_byte, is_error, error_code, run_last, copy_pending,
                  block_total, input ready);
  modport sink   (input valid, out_byte, is_error, error_code, run_last, copy_pending,
                  block_total, output ready);
endinterface

// ===== sv/lzmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lzmd_ctrl
// Sequencer: accepts a transaction, commits its decode step, then runs the
// copy burst as ring read / emit pairs.
// ----------------------------------------------------------------------------
module lzmd_ctrl
  import lzmd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  lzmd_status_t st,
  output lzmd_cmd_t    cmd
);

  lzmd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (!st.dec_result || st.slot_free) begin
          state_nxt = st.dec_copy ? S_READ : S_IDLE;
        end
      end
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.slot_free) state_nxt = st.copy_more ? S_READ : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECODE: begin
        cmd.decode = !st.dec_result || st.slot_free;
      end
      S_READ: begin
        cmd.read = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = st.slot_free;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> ($past(state_r) == S_READ || $past(state_r) == S_EMIT))
    else $error("emit without a preceding ring read");
  a_read_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.read |=> (state_r == S_EMIT))
    else $error("ring read not followed by emit");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.decode, cmd.read, cmd.emit}))
    else $error("more than one command at once");
`endif

endmodule

// ===== sv/lzmd_dp.sv =====
// ----------------------------------------------------------------------------
// lzmd_dp
// Datapath: transaction latch, decode state, varint accumulator, history
// ring and the result register.
// ----------------------------------------------------------------------------
module lzmd_dp
  import lzmd_pkg::*;
#(
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
  parameter int BURST_MAX    = BURST_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  lzmd_cmd_t    cmd,
  output lzmd_status_t st,
  input  logic         in_action,
  input  logic [7:0]   in_byte,
  input  logic         in_last_of_block,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   out_byte,
  output logic         out_is_error,
  output logic [1:0]   out_error_code,
  output logic         out_run_last,
  output logic         out_copy_pending,
  output logic [31:0]  out_block_total
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int HW = $clog2(WINDOW_BYTES + 1);
  localparam int BW = $clog2(BURST_MAX + 1);
  localparam logic [AW-1:0] WP_LAST = AW'(WINDOW_BYTES - 1);
  localparam logic [HW-1:0] WIN_H   = HW'(WINDOW_BYTES);
  localparam logic [BW-1:0] BURST_C = BW'(BURST_MAX);

  // transaction latch
  logic       act_r, last_r;
  logic [7:0] byte_r;

  // decode state
  lzmd_mode_t  mode_r, mode_nxt;
  logic [7:0]  marker_r, marker_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] copy_rem_r, copy_rem_nxt;
  logic [HW-1:0] dist_r, dist_nxt;
  logic [AW-1:0] wp_r;
  logic [HW-1:0] held_r;
  logic [31:0]   produced_r;
  logic [BW-1:0] burst_r;

  logic [7:0] ring [WINDOW_BYTES];
  logic [7:0] ring_q_r;

  // result register
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_err_r;
  logic [1:0]  out_code_r;
  logic        out_last_r;
  logic        out_pend_r;
  logic [31:0] out_total_r;

  // decode step
  logic        dec_result, dec_copy, dec_push, dec_header;
  logic [7:0]  res_byte;
  logic        res_err;
  lzmd_err_t   res_code;
  logic [31:0] acc_shift, off;
  logic        cont;

  // ring side
  logic          push;
  logic [7:0]    push_byte;
  logic [AW-1:0] wp_inc;
  logic [HW-1:0] wp_h, rd_h;
  logic [AW-1:0] rd_addr;
  logic [31:0]   produced_inc, copy_dec;
  logic [BW-1:0] burst_inc;
  logic          slot_free, load_out;

  assign acc_shift = {accum_r[24:0], byte_r[6:0] & VARINT_MASK};
  assign off       = acc_shift;
  assign cont      = byte_r[VARINT_MORE];

  always_comb begin
    mode_nxt     = mode_r;
    marker_nxt   = marker_r;
    accum_nxt    = accum_r;
    len_nxt      = len_r;
    copy_rem_nxt = copy_rem_r;
    dist_nxt     = dist_r;
    dec_result   = 1'b0;
    dec_copy     = 1'b0;
    dec_push     = 1'b0;
    dec_header   = 1'b0;
    res_byte     = 8'd0;
    res_err      = 1'b0;
    res_code     = ERR_NONE;
    if (act_r) begin
      dec_copy = (copy_rem_r != 32'd0);
    end else if (copy_rem_r != 32'd0) begin
      copy_rem_nxt = 32'd0;
      dec_result   = 1'b1;
      res_err      = 1'b1;
      res_code     = ERR_BUSY;
    end else begin
      unique case (mode_r)
        MODE_HEADER: begin
          marker_nxt = byte_r;
          dec_header = 1'b1;
          mode_nxt   = MODE_PLAIN;
        end
        MODE_AFTER_MARKER: begin
          if (byte_r == 8'd0) begin
            dec_push   = 1'b1;
            dec_result = 1'b1;
            res_byte   = marker_r;
            mode_nxt   = MODE_PLAIN;
          end else if (cont) begin
            accum_nxt = {25'd0, byte_r[6:0] & VARINT_MASK};
            mode_nxt  = MODE_LENGTH;
          end else begin
            len_nxt   = {25'd0, byte_r[6:0] & VARINT_MASK};
            accum_nxt = 32'd0;
            mode_nxt  = MODE_OFFSET;
          end
        end
        MODE_LENGTH: begin
          accum_nxt = acc_shift;
          if (!cont) begin
            len_nxt   = acc_shift;
            accum_nxt = 32'd0;
            mode_nxt  = MODE_OFFSET;
          end
        end
        MODE_OFFSET: begin
          accum_nxt = acc_shift;
          if (!cont) begin
            accum_nxt = 32'd0;
            mode_nxt  = MODE_PLAIN;
            if (off == 32'd0 || off > 32'(held_r)) begin
              dec_result = 1'b1;
              res_err    = 1'b1;
              res_code   = ERR_OFFSET;
            end else begin
              dist_nxt     = off[HW-1:0];
              copy_rem_nxt = len_r;
              dec_copy     = (len_r != 32'd0);
            end
          end
        end
        default: begin
          if (byte_r == marker_r) begin
            mode_nxt = MODE_AFTER_MARKER;
          end else begin
            dec_push   = 1'b1;
            dec_result = 1'b1;
            res_byte   = byte_r;
          end
        end
      endcase
    end
    if (!act_r && last_r) begin
      mode_nxt  = MODE_HEADER;
      accum_nxt = 32'd0;
    end
  end

  assign push         = (cmd.decode && dec_push) || cmd.emit;
  assign push_byte    = cmd.emit ? ring_q_r : res_byte;
  assign wp_inc       = (wp_r == WP_LAST) ? '0 : wp_r + AW'(1);
  assign produced_inc = (produced_r == 32'hffff_ffff) ? produced_r : produced_r + 32'd1;
  assign copy_dec     = copy_rem_r - 32'd1;
  assign burst_inc    = burst_r + BW'(1);
  assign wp_h         = HW'(wp_r);
  assign rd_h         = (wp_h >= dist_r) ? wp_h - dist_r : wp_h + (WIN_H - dist_r);
  assign rd_addr      = rd_h[AW-1:0];
  assign slot_free    = !out_valid_r || out_ready;
  assign load_out     = (cmd.decode && dec_result) || cmd.emit;

  assign st.slot_free  = slot_free;
  assign st.dec_result = dec_result;
  assign st.dec_copy   = dec_copy;
  assign st.copy_more  = (copy_dec != 32'd0) && (burst_inc != BURST_C);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      byte_r <= in_byte;
      last_r <= in_last_of_block;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ring[wp_r] <= push_byte;
    if (cmd.read) ring_q_r <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_HEADER;
      marker_r   <= 8'd0;
      accum_r    <= 32'd0;
      len_r      <= 32'd0;
      copy_rem_r <= 32'd0;
      dist_r     <= '0;
      wp_r       <= '0;
      held_r     <= '0;
      produced_r <= 32'd0;
      burst_r    <= '0;
    end else begin
      if (cmd.decode) begin
        mode_r     <= mode_nxt;
        marker_r   <= marker_nxt;
        accum_r    <= accum_nxt;
        len_r      <= len_nxt;
        copy_rem_r <= copy_rem_nxt;
        dist_r     <= dist_nxt;
        burst_r    <= '0;
        if (dec_header) begin
          held_r     <= '0;
          produced_r <= 32'd0;
        end
      end
      if (cmd.emit) begin
        copy_rem_r <= copy_dec;
        burst_r    <= burst_inc;
      end
      if (push) begin
        wp_r       <= wp_inc;
        held_r     <= (held_r < WIN_H) ? held_r + HW'(1) : held_r;
        produced_r <= produced_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (cmd.emit) begin
        out_byte_r  <= ring_q_r;
        out_err_r   <= 1'b0;
        out_code_r  <= ERR_NONE;
        out_last_r  <= !st.copy_more;
        out_pend_r  <= (copy_dec != 32'd0);
        out_total_r <= produced_inc;
      end else begin
        out_byte_r  <= res_byte;
        out_err_r   <= res_err;
        out_code_r  <= res_code;
        out_last_r  <= 1'b1;
        out_pend_r  <= 1'b0;
        out_total_r <= dec_push ? produced_inc : produced_r;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_is_error     = out_err_r;
  assign out_error_code   = out_code_r;
  assign out_run_last     = out_last_r;
  assign out_copy_pending = out_pend_r;
  assign out_block_total  = out_total_r;

`ifndef SYNTHESIS
  a_copy_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (copy_rem_r != 32'd0) |-> (dist_r != '0 && dist_r <= held_r))
    else $error("pending copy reaches outside held bytes");
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= WIN_H)
    else $error("held byte count beyond window");
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_byte_r == 8'd0 && !out_pend_r && out_last_r))
    else $error("error result carries data");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> slot_free)
    else $error("result register loaded while occupied");
`endif

endmodule

// ===== sv/lz77_marker_decompressor.sv =====
// ----------------------------------------------------------------------------
// lz77_marker_decompressor
// Streaming marker-byte LZ77 decoder with varint length/offset and a
// history ring for overlapping copies.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  in_ch   | in  | action, in_byte, last_of_block
//  out_ch  | out | out_byte, is_error, error_code, run_last, copy_pending,
//          |     | block_total
//
//  A transaction is accepted, then decoded; a copy then runs byte by byte
//  as a ring read, then ring write and emit, up to BURST_MAX bytes per transaction.
//  The ring memory's single registered read port sets the copy rate.
//  Synchronous active-low reset; the ring is not cleared, no startup pass.
//  A stalled output holds the sequencer when a result is due; transactions
//  that yield no result are still taken while an earlier result waits.
// ----------------------------------------------------------------------------
module lz77_marker_decompressor
  import lzmd_pkg::*;
#(
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
  parameter int BURST_MAX    = BURST_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lzmd_in_if.sink   in_ch,
  lzmd_out_if.source out_ch
);

  lzmd_cmd_t    cmd;
  lzmd_status_t st;

  lzmd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  lzmd_dp #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .BURST_MAX    (BURST_MAX)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_action        (in_ch.action),
    .in_byte          (in_ch.in_byte),
    .in_last_of_block (in_ch.last_of_block),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_byte         (out_ch.out_byte),
    .out_is_error     (out_ch.is_error),
    .out_error_code   (out_ch.error_code),
    .out_run_last     (out_ch.run_last),
    .out_copy_pending (out_ch.copy_pending),
    .out_block_total  (out_ch.block_total)
  );

endmodule

// ===== verif/tb_lz77_marker_decompressor.sv =====
// ----------------------------------------------------------------------------
// tb_lz77_marker_decompressor
// Self-checking bench for the marker-byte LZ77 decompressor. Directed
// blocks cover literal and escaped markers, overlapping and zero-length
// copies, bad offsets, varint overflow, long copies drained by ticks, bytes
// that cut into a copy, and truncated codes. A random part follows, made of
// blocks with random markers and random tokens. A scoreboard tracks the
// history ring and decoder state and predicts every result.
// ----------------------------------------------------------------------------
module tb_lz77_marker_decompressor;
  timeunit 1ns;
  timeprecision 1ps;

  import lzmd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int ITEM_TARGET = 400;
  localparam int PHASE_ITEMS = 70;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic [7:0]  out_byte;
    logic        is_error;
    lzmd_err_t   error_code;
    logic        run_last;
    logic        copy_pending;
    logic [31:0] block_total;
  } decoded_t;

  class lz_stream_scoreboard;
    logic [7:0]  ring [WINDOW_BYTES_DEF];
    lzmd_mode_t  mode;
    logic [7:0]  marker;
    logic [31:0] accum;
    logic [31:0] match_len;
    logic [31:0] copy_left;
    logic [17:0] copy_dist;
    logic [16:0] wr_ptr;
    logic [17:0] held;
    logic [31:0] produced;
    decoded_t    expected_q[$];
    int          errors;

    function new();
      mode      = MODE_HEADER;
      marker    = '0;
      accum     = '0;
      match_len = '0;
      copy_left = '0;
      copy_dist = '0;
      wr_ptr    = '0;
      held      = '0;
      produced  = '0;
      errors    = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_out(logic [7:0] b, logic err, lzmd_err_t code, logic pend);
      decoded_t r;
      r.out_byte     = b;
      r.is_error     = err;
      r.error_code   = code;
      r.run_last     = 1'b0;
      r.copy_pending = pend;
      r.block_total  = produced;
      expected_q.push_back(r);
    endfunction

    function void emit_byte(logic [7:0] b);
      ring[wr_ptr] = b;
      wr_ptr = wr_ptr + 17'd1;
      if (held < 18'(WINDOW_BYTES_DEF)) held = held + 18'd1;
      if (produced != 32'hffff_ffff) produced = produced + 32'd1;
      push_out(b, 1'b0, ERR_NONE, copy_left != 0);
    endfunction

    function void drain();
      int          n;
      logic [17:0] d;
      logic [16:0] rd;
      n = 0;
      while (copy_left != 0 && n < BURST_MAX_DEF) begin
        d = copy_dist;
        if (d > 18'(WINDOW_BYTES_DEF)) d = 18'(WINDOW_BYTES_DEF);
        rd = wr_ptr - d[16:0];
        copy_left = copy_left - 32'd1;
        emit_byte(ring[rd]);
        n++;
      end
    endfunction

    function void note_input(logic act, logic [7:0] b, logic last);
      int          first;
      decoded_t    r;
      logic [31:0] off;
      first = expected_q.size();
      if (act) begin
        drain();
      end else if (copy_left != 0) begin
        copy_left = '0;
        push_out(8'h00, 1'b1, ERR_BUSY, 1'b0);
      end else begin
        case (mode)
          MODE_HEADER: begin
            marker   = b;
            produced = '0;
            held     = '0;
            mode     = MODE_PLAIN;
          end
          MODE_AFTER_MARKER: begin
            if (b == 8'h00) begin
              emit_byte(marker);
              mode = MODE_PLAIN;
            end else begin
              accum = {25'd0, b[6:0]};
              if (b[7]) begin
                mode = MODE_LENGTH;
              end else begin
                match_len = accum;
                accum     = '0;
                mode      = MODE_OFFSET;
              end
            end
          end
          MODE_LENGTH: begin
            accum = {accum[24:0], b[6:0]};
            if (!b[7]) begin
              match_len = accum;
              accum     = '0;
              mode      = MODE_OFFSET;
            end
          end
          MODE_OFFSET: begin
            accum = {accum[24:0], b[6:0]};
            if (!b[7]) begin
              off   = accum;
              accum = '0;
              mode  = MODE_PLAIN;
              if (off == 0 || off > {14'd0, held}) begin
                push_out(8'h00, 1'b1, ERR_OFFSET, 1'b0);
              end else begin
                copy_dist = off[17:0];
                copy_left = match_len;
                drain();
              end
            end
          end
          default: begin
            if (b == marker) mode = MODE_AFTER_MARKER;
            else emit_byte(b);
          end
        endcase
      end
      if (!act && last) begin
        mode  = MODE_HEADER;
        accum = '0;
      end
      if (expected_q.size() > first) begin
        r = expected_q[expected_q.size() - 1];
        r.run_last = 1'b1;
        expected_q[expected_q.size() - 1] = r;
      end
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(decoded_t got);
      decoded_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: out_byte 0x%0h is_error %0b",
               got.out_byte, got.is_error);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      cmp_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
      cmp_field("is_error", 32'(want.is_error), 32'(got.is_error));
      cmp_field("error_code", 32'(want.error_code), 32'(got.error_code));
      cmp_field("run_last", 32'(want.run_last), 32'(got.run_last));
      cmp_field("copy_pending", 32'(want.copy_pending), 32'(got.copy_pending));
      cmp_field("block_total", want.block_total, got.block_total);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  lzmd_in_if  in_ch ();
  lzmd_out_if out_ch ();

  lz77_marker_decompressor u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lz_stream_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int quiet_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    decoded_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.out_byte     = out_ch.out_byte;
        got.is_error     = out_ch.is_error;
        got.error_code   = lzmd_err_t'(out_ch.error_code);
        got.run_last     = out_ch.run_last;
        got.copy_pending = out_ch.copy_pending;
        got.block_total  = out_ch.block_total;
        sb.check_result(got);
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_lz77_marker_decompressor: errors");
        $finish;
      end
    end
  end

  task automatic send_item(input logic act, input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= act;
    in_ch.in_byte       <= b;
    in_ch.last_of_block <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(act, b, last);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    send_item(1'b0, b, last);
  endtask

  task automatic send_tick();
    send_item(1'b1, 8'($urandom), 1'($urandom));
  endtask

  // style: 0 minimal groups, 1 leading zero groups, 2 prefix shifted out of 32 bits
  task automatic send_varint(input logic [31:0] v, input bit is_len, input int style,
                             input logic last);
    int groups;
    groups = 1;
    while (groups < 5 && (v >> (7 * groups)) != 0) groups++;
    if (style == 2) begin
      send_byte(8'h80 | 8'($urandom_range(1, 127)), 1'b0);
      repeat (4) send_byte(8'h80, 1'b0);
    end else if (style == 1 || (is_len && v == 0)) begin
      repeat ($urandom_range(1, 2)) send_byte(8'h80, 1'b0);
    end
    for (int i = groups - 1; i >= 0; i--)
      send_byte({i != 0, 7'(v >> (7 * i))}, (i == 0) ? last : 1'b0);
  endtask

  function automatic logic [7:0] non_marker_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == sb.marker) b = b ^ 8'h01;
    return b;
  endfunction

  task automatic run_block();
    int          tokens;
    int          r;
    int          lim;
    int          k;
    logic [7:0]  mk;
    logic [31:0] len;
    logic [31:0] off;
    bit          fin;
    bit          ended;
    r = $urandom_range(99);
    mk = (r < 15) ? 8'h00 : (r < 30) ? 8'hff : 8'($urandom);
    send_byte(mk, 1'b0);
    tokens = $urandom_range(1, 24);
    ended = 1'b0;
    for (int t = 0; t < tokens && !ended; t++) begin
      fin = (t == tokens - 1);
      r = $urandom_range(99);
      if (r < 40) begin
        send_byte(non_marker_byte(), fin);
      end else if (r < 50) begin
        send_byte(sb.marker, 1'b0);
        send_byte(8'h00, fin);
      end else if (r < 85) begin
        r = $urandom_range(99);
        len = (r < 5)  ? 32'd0 :
              (r < 70) ? 32'($urandom_range(1, 16)) :
              (r < 92) ? 32'($urandom_range(17, 130)) : 32'($urandom_range(131, 300));
        r = $urandom_range(99);
        lim = (sb.held > 16) ? 16 : int'(sb.held);
        if (sb.held == 0 || r < 8)
          off = r[0] ? 32'd0 : 32'(sb.held) + 32'($urandom_range(1, 300));
        else if (r < 70)
          off = 32'($urandom_range(1, lim));
        else
          off = 32'($urandom_range(1, int'(sb.held)));
        send_byte(sb.marker, 1'b0);
        r = $urandom_range(99);
        send_varint(len, 1'b1, (r < 80) ? 0 : (r < 92) ? 1 : 2, 1'b0);
        r = $urandom_range(99);
        send_varint(off, 1'b0, (r < 80) ? 0 : (r < 92) ? 1 : 2, fin);
        while (sb.copy_left != 0) begin
          if ($urandom_range(99) < 6) send_byte(8'($urandom), 1'b0);
          else send_tick();
        end
      end else if (r < 90) begin
        // code cut short by the end of the block
        k = $urandom_range(0, 3);
        send_byte(sb.marker, k == 0);
        for (int j = 0; j < k; j++) send_byte(8'h80 | 8'($urandom), j == k - 1);
        ended = 1'b1;
      end else if (r < 95) begin
        send_byte(8'($urandom), 1'($urandom));
      end else begin
        send_tick();
      end
    end
    while (sb.copy_left != 0) send_tick();
    if (sb.mode != MODE_HEADER) send_byte(non_marker_byte(), 1'b1);
    while (sb.copy_left != 0) send_tick();
  endtask

  initial begin
    int phase;
    int next_phase;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.action        <= 1'b0;
    in_ch.in_byte       <= 8'h00;
    in_ch.last_of_block <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // block with marker 0xff
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    // overlapping copy
    send_byte(8'hff, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h02, 1'b0);
    // offset zero
    send_byte(8'hff, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h00, 1'b0);
    // offset beyond bytes held
    send_byte(8'hff, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h00, 1'b0);
    // overflowing length varint that leaves zero, then a valid offset
    send_byte(8'hff, 1'b0);
    send_byte(8'h81, 1'b0);
    repeat (4) send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    // long copy ending the block, partly drained by a tick, then cut by a byte
    send_byte(8'hff, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h01, 1'b1);
    send_tick();
    send_byte(8'h55, 1'b0);
    send_tick();
    // block with marker 0x00, ends right after a marker
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);

    phase = -1;
    while (items_sent < ITEM_TARGET) begin
      next_phase = (items_sent / PHASE_ITEMS) % 4;
      if (next_phase != phase) begin
        // hold off until everything predicted has come back
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        phase = next_phase;
        case (phase)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
          default: begin send_idle_pct = 6; recv_stall_pct = 6; end
        endcase
      end
      run_block();
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_lz77_marker_decompressor: clean");
    else
      $display("tb_lz77_marker_decompressor: errors");
    $finish;
  end

endmodule
